// File: hw/rtl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants for the first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

    // Heap geometry
    localparam int HEAP_WORDS = 64;
    localparam int ADDR_W     = $clog2(HEAP_WORDS);
    localparam int HDR_W      = 10;   // header word width (size in bytes, bit 0 busy)
    localparam int REQ_W      = 10;   // request_bytes width
    localparam int IDX_W      = 6;    // payload index width
    localparam int NEED_W     = REQ_W + 1;   // rounded size, up to 1024
    localparam int CMP_W      = NEED_W + 1;  // room for need + MIN_SPLIT
    localparam int WORD_SHIFT = 3;
    localparam int WORD_BYTES = 8;
    localparam int MIN_SPLIT  = 16;
    localparam int ROUND_ADD  = WORD_BYTES - 1;

    // Walk position: current header plus the largest hop a header allows
    localparam int POS_W = $clog2(HEAP_WORDS + (1 << (HDR_W - WORD_SHIFT))) + 1;

    // Header of word 0 after reset: the whole heap, free
    localparam logic [HDR_W-1:0] HEAP_RESET_HDR = HDR_W'(HEAP_WORDS * WORD_BYTES - WORD_BYTES);

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_NO_MEMORY = 2'd1,
        ST_FREED     = 2'd2,
        ST_IGNORED   = 2'd3
    } status_t;

    typedef struct packed {
        op_t              op;
        logic [REQ_W-1:0] request_bytes;
        logic [IDX_W-1:0] release_index;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] payload_index;
    } rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over an implicit list of headers in a 64-word heap.
// ----------------------------------------------------------------------------
// The heap is HEAP_WORDS words of 8 bytes; each block is a header word (size
// in bytes, bit 0 busy) followed by its payload. An allocate request walks the
// header list from word 0 and takes the first free block that holds the size
// rounded up to 8 bytes, splitting it when 16 or more bytes would be left.
// A free request clears the busy bit of the header in front of the given
// payload word. Only headers are stored, in a single-port-write,
// registered-read header memory; the walk reads one header per cycle.
// A free of word 0 is ignored. One request is in flight at a time;
// req_ready is high only while the sequencer idles. The result sits in an
// output register, so a new request can be taken while the previous result
// waits for rsp_ready. No clearing pass is needed after reset: per-word
// valid bits make unwritten headers read as their reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator
    import ffa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,

    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,

    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_READ      = 6'b000010,  // first header read issued
        S_ALLOC_CHK = 6'b000100,  // header data back, one header per cycle
        S_FREE_CHK  = 6'b001000,
        S_SPLIT     = 6'b010000,  // write the trailing free header
        S_DONE      = 6'b100000   // hand result to the output register
    } state_t;

    state_t state_reg, state_next;

    op_t              op_reg, op_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [ADDR_W-1:0] rest_pos_reg, rest_pos_next;
    logic [HDR_W-1:0] rest_hdr_reg, rest_hdr_next;
    rsp_t             result_reg, result_next;
    rsp_t             rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // Header memory with per-word valid bits
    logic [HDR_W-1:0]      hdr_mem [HEAP_WORDS];
    logic [HEAP_WORDS-1:0] valid_reg;
    logic [HDR_W-1:0]      rd_data_reg;
    logic                  rd_valid_reg;
    logic [ADDR_W-1:0]     rd_addr_reg;

    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [HDR_W-1:0]  wr_data;

    // Datapath around the header just read
    logic [HDR_W-1:0]  hdr;
    logic [HDR_W-1:0]  size;
    logic [CMP_W-1:0]  need_ext;
    logic [CMP_W-1:0]  size_ext;
    logic              fits;
    logic              split;
    logic [POS_W-1:0]  pos_plus1;
    logic [POS_W-1:0]  next_pos;
    logic [POS_W-1:0]  rest_pos_full;
    logic [HDR_W-1:0]  rest_hdr;
    logic [NEED_W-1:0] round_sum;
    logic              rsp_free;

    assign hdr = rd_valid_reg ? rd_data_reg
               : ((rd_addr_reg == '0) ? HEAP_RESET_HDR : '0);
    assign size     = {hdr[HDR_W-1:1], 1'b0};
    assign need_ext = CMP_W'(need_reg);
    assign size_ext = CMP_W'(size);
    assign pos_plus1 = pos_reg + POS_W'(1);

    // Free, large enough, and payload word still inside the heap
    assign fits  = !hdr[0] && (need_ext <= size_ext)
                && (pos_plus1 < POS_W'(HEAP_WORDS));
    assign split = size_ext >= (need_ext + CMP_W'(MIN_SPLIT));

    assign next_pos      = pos_plus1 + POS_W'(size >> WORD_SHIFT);
    assign rest_pos_full = pos_plus1 + POS_W'(need_reg >> WORD_SHIFT);
    assign rest_hdr      = HDR_W'(size_ext - need_ext - CMP_W'(WORD_BYTES));

    assign round_sum = NEED_W'(req.request_bytes) + NEED_W'(ROUND_ADD);

    // Output slot can take a new result this cycle
    assign rsp_free = !rsp_valid_reg || rsp_ready;

    // While walking, the next header is fetched straight from the hop adder
    assign rd_addr = (state_reg == S_ALLOC_CHK) ? next_pos[ADDR_W-1:0]
                                                : pos_reg[ADDR_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        need_next      = need_reg;
        rest_pos_next  = rest_pos_reg;
        rest_hdr_next  = rest_hdr_reg;
        result_next    = result_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        wr_en          = 1'b0;
        wr_addr        = pos_reg[ADDR_W-1:0];
        wr_data        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next = req.op;
                    if (req.op == OP_ALLOC)
                    begin
                        need_next  = {round_sum[NEED_W-1:WORD_SHIFT], {WORD_SHIFT{1'b0}}};
                        pos_next   = '0;
                        state_next = S_READ;
                    end
                    else if ((req.release_index == '0)
                          || (POS_W'(req.release_index) >= POS_W'(HEAP_WORDS)))
                    begin
                        // no header in front of this word
                        result_next = '{status: ST_IGNORED, payload_index: '0};
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        pos_next   = POS_W'(req.release_index) - POS_W'(1);
                        state_next = S_READ;
                    end
                end
            end

            S_READ:
            begin
                state_next = (op_reg == OP_ALLOC) ? S_ALLOC_CHK : S_FREE_CHK;
            end

            S_ALLOC_CHK:
            begin
                if (fits)
                begin
                    wr_en       = 1'b1;
                    wr_addr     = pos_reg[ADDR_W-1:0];
                    result_next = '{status: ST_ALLOCATED,
                                    payload_index: IDX_W'(pos_plus1)};
                    if (split)
                    begin
                        wr_data       = HDR_W'(need_reg) + HDR_W'(1);
                        rest_pos_next = rest_pos_full[ADDR_W-1:0];
                        rest_hdr_next = rest_hdr;
                        // split header beyond the heap end is dropped
                        state_next    = (rest_pos_full < POS_W'(HEAP_WORDS)) ? S_SPLIT
                                                                             : S_DONE;
                    end
                    else
                    begin
                        wr_data    = hdr + HDR_W'(1);
                        state_next = S_DONE;
                    end
                end
                else if (next_pos < POS_W'(HEAP_WORDS))
                begin
                    pos_next = next_pos;
                end
                else
                begin
                    result_next = '{status: ST_NO_MEMORY, payload_index: '0};
                    state_next  = S_DONE;
                end
            end

            S_FREE_CHK:
            begin
                if (hdr[0])
                begin
                    wr_en       = 1'b1;
                    wr_addr     = pos_reg[ADDR_W-1:0];
                    wr_data     = hdr - HDR_W'(1);
                    result_next = '{status: ST_FREED, payload_index: '0};
                end
                else
                begin
                    result_next = '{status: ST_IGNORED, payload_index: '0};
                end
                state_next = S_DONE;
            end

            S_SPLIT:
            begin
                wr_en      = 1'b1;
                wr_addr    = rest_pos_reg;
                wr_data    = rest_hdr_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_next       = result_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Header memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hdr_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= hdr_mem[rd_addr];
        rd_addr_reg <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pos_reg      <= pos_next;
        need_reg     <= need_next;
        rest_pos_reg <= rest_pos_next;
        rest_hdr_reg <= rest_hdr_next;
        result_reg   <= result_next;
        rsp_reg      <= rsp_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
